// ----- hdl/gbnms_pkg.sv -----
package gbnms_pkg;

  // Configuration register indexes
  localparam logic REG_IOU_THRESHOLD  = 1'b0;
  localparam logic REG_CLASS_AGNOSTIC = 1'b1;

  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;  // 0.45 in Q0.16

  // One stored table entry
  typedef struct packed {
    logic [7:0]  label;
    logic [29:0] area;
    logic [14:0] height;
    logic [14:0] width;
    logic [15:0] top;
    logic [15:0] left;
  } kept_t;

  // Box under test plus the settings that apply to it
  typedef struct packed {
    kept_t       box;
    logic [15:0] thr;
    logic        agnostic;
  } cur_t;

  // Sequencer to compare unit
  typedef struct packed {
    logic clear;
    logic issue;
  } iou_ctl_t;

  // Compare unit to sequencer
  typedef struct packed {
    logic busy;
    logic suppress;
  } iou_sts_t;

endpackage

// ----- hdl/gbnms_mem.sv -----
module gbnms_mem
  import gbnms_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  kept_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output kept_t         rd_data
);

  kept_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/gbnms_iou.sv -----
module gbnms_iou
  import gbnms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  iou_ctl_t ctl,
  input  cur_t     cur,
  input  kept_t    kept,   // table read data, valid in the cycle after issue
  output iou_sts_t sts
);

  logic v1, va, vb, vc, vd, ve;
  logic suppress;

  // stage A: edges of the overlap rectangle
  logic signed [17:0] c_r, c_b, k_r, k_b, x2_n, y2_n;
  logic signed [15:0] x1_n, y1_n;
  logic signed [15:0] x1_a, y1_a;
  logic signed [17:0] x2_a, y2_a;
  logic               match_a;
  logic [29:0]        karea_a;

  // stage B: clamped extents
  logic signed [18:0] dx_n, dy_n;
  logic [14:0]        dx_b, dy_b;
  logic               match_b;
  logic [29:0]        karea_b;

  // stage C: intersection
  logic [29:0] inter_c;
  logic        match_c;
  logic [29:0] karea_c;

  // stage D: union
  logic [30:0] uni_d;
  logic [29:0] inter_d;
  logic        match_d;

  // stage E: threshold times union
  logic [46:0] prod_e;
  logic [29:0] inter_e;
  logic        match_e;

  always_comb begin
    c_r = {{2{cur.box.left[15]}}, cur.box.left} + {3'b000, cur.box.width};
    c_b = {{2{cur.box.top[15]}}, cur.box.top} + {3'b000, cur.box.height};
    k_r = {{2{kept.left[15]}}, kept.left} + {3'b000, kept.width};
    k_b = {{2{kept.top[15]}}, kept.top} + {3'b000, kept.height};
    x1_n = ($signed(cur.box.left) > $signed(kept.left)) ? cur.box.left : kept.left;
    y1_n = ($signed(cur.box.top) > $signed(kept.top)) ? cur.box.top : kept.top;
    x2_n = (c_r < k_r) ? c_r : k_r;
    y2_n = (c_b < k_b) ? c_b : k_b;
    dx_n = {x2_a[17], x2_a} - {{3{x1_a[15]}}, x1_a};
    dy_n = {y2_a[17], y2_a} - {{3{y1_a[15]}}, y1_a};
  end

  always_ff @(posedge clk) begin
    // A
    x1_a    <= x1_n;
    y1_a    <= y1_n;
    x2_a    <= x2_n;
    y2_a    <= y2_n;
    match_a <= cur.agnostic || (kept.label == cur.box.label);
    karea_a <= kept.area;
    // B: a non-positive extent means no overlap at all
    if (dx_n > 19'sd0 && dy_n > 19'sd0) begin
      dx_b <= dx_n[14:0];
      dy_b <= dy_n[14:0];
    end else begin
      dx_b <= '0;
      dy_b <= '0;
    end
    match_b <= match_a;
    karea_b <= karea_a;
    // C
    inter_c <= dx_b * dy_b;
    match_c <= match_b;
    karea_c <= karea_b;
    // D
    uni_d   <= {1'b0, cur.box.area} + {1'b0, karea_c} - {1'b0, inter_c};
    inter_d <= inter_c;
    match_d <= match_c;
    // E
    prod_e  <= cur.thr * uni_d;
    inter_e <= inter_d;
    match_e <= match_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      suppress <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      va <= v1;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      if (ctl.clear) begin
        suppress <= 1'b0;
      end else if (ve && match_e && ({1'b0, inter_e, 16'h0000} > prod_e)) begin
        suppress <= 1'b1;
      end
    end
  end

  assign sts.busy     = v1 | va | vb | vc | vd | ve;
  assign sts.suppress = suppress;

endmodule

// ----- hdl/greedy_box_nms.sv -----
// Greedy box suppression, one box item at a time.
// After accept, the box area is computed, then one kept entry is read and compared
// per cycle through compare stages A to E; once they drain, the keep decision is
// posted. The result register lets the next item enter while a result still waits
// downstream.
// Reset (rst, synchronous, active high): table empty, IoU settings at defaults.
module greedy_box_nms
  import gbnms_pkg::*;
#(
  parameter int MAX_KEPT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input boxes
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] box_left, [31:16] box_top, [46:32] box_width,
  // [61:47] box_height, [69:62] class_label, [71:70] zero
  input  logic [71:0] s_tdata,
  input  logic [0:0]  s_tuser,   // [0] frame_start
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] keep, [8:1] kept_slot, [9] table_full, [15:10] zero
  output logic [15:0] m_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam logic [CW-1:0] KMAX = CW'(MAX_KEPT);

  typedef enum logic [2:0] {IDLE, AREA, SCAN, DRAIN, FINISH} state_t;

  state_t      state;
  kept_t       box;       // box under test
  logic [15:0] thr;       // IoU threshold, Q0.16
  logic        agnostic;  // compare across classes
  cur_t        cur;
  logic [CW-1:0] count;     // valid table entries
  logic [CW-1:0] j;         // next entry to read
  iou_ctl_t    ctl;
  iou_sts_t    sts;
  kept_t       rd_data;
  logic        out_free;
  logic        keep;
  logic        has_room;
  logic        wr_en;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);

  assign cur = '{box: box, thr: thr, agnostic: agnostic};

  assign out_free = !m_tvalid || m_tready;
  assign keep     = !sts.suppress;
  assign has_room = (count < KMAX);
  assign wr_en    = (state == FINISH) && out_free && keep && has_room;

  assign ctl.clear = (state == AREA);
  assign ctl.issue = (state == SCAN) && (j != count);

  // Config registers; writes are expected only while no box is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= IOU_THRESHOLD_RESET;
      agnostic <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IOU_THRESHOLD:  thr      <= cfg_data;
        REG_CLASS_AGNOSTIC: agnostic <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      j        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result valid: set when a decision is posted, cleared once taken
      if (state == FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            box.left   <= s_tdata[15:0];
            box.top    <= s_tdata[31:16];
            box.width  <= s_tdata[46:32];
            box.height <= s_tdata[61:47];
            box.label  <= s_tdata[69:62];
            if (s_tuser[0]) begin
              count <= '0;
            end
            state <= AREA;
          end
        end
        AREA: begin
          box.area <= box.width * box.height;
          j        <= '0;
          state    <= SCAN;
        end
        SCAN: begin
          if (j == count) begin
            state <= DRAIN;
          end else begin
            j <= j + 1'b1;
          end
        end
        DRAIN: begin
          if (!sts.busy) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tdata <= {6'b000000, keep && !has_room,
                        (keep && has_room) ? 8'(count) : 8'h00, keep};
            if (keep && has_room) begin
              count <= count + 1'b1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  gbnms_mem #(
    .DEPTH (MAX_KEPT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (box),
    .rd_addr (j[AW-1:0]),
    .rd_data (rd_data)
  );

  gbnms_iou u_iou (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cur  (cur),
    .kept (rd_data),
    .sts  (sts)
  );

endmodule

// ----- hdl/gbnms_chk.sv -----
module gbnms_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a result waits until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before taken");

  // one box in flight: no accept right after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted while busy");

  // suppressed box carries no slot and no full flag
  a_supp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[9:1] == 9'd0)
    else $error("suppressed result with slot or full flag");

  // full flag only on a kept box, and then slot zero
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[0] && m_tdata[8:1] == 8'd0)
    else $error("bad table full result");

endmodule

bind greedy_box_nms gbnms_chk u_chk (.*);
